// File: src/ippl_pkg.sv
// Package for the incremental PID position loop: widths, loop constants,
// register indexes, direction codes and the accumulator clamp.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ippl_pkg;

  // field widths
  localparam int COUNT_W = 21;
  localparam int PHASE_W = 19;
  localparam int PDIV_W  = 15;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 21;
  localparam int IDX_W   = 3;
  localparam int DUTY_W  = 12;
  localparam int DIR_W   = 2;
  localparam int ERR_W   = 21;

  // internal widths
  localparam int PROD_W = 42;  // (target - count) * period
  localparam int ERRX_W = 43;  // unclamped error
  localparam int E_W    = 32;  // error scaled by 1024
  localparam int NUM_W  = 34;  // second difference of scaled errors
  localparam int DVS_W  = 30;  // largest combined divisor
  localparam int CNT_W  = 6;   // divider step count
  localparam int ACC_W  = 22;  // clamped accumulators
  localparam int SUMQ_W = 36;  // accumulator plus quotient
  localparam int SUM3_W = 24;  // sum of three accumulators

  // loop constants
  localparam logic signed [COUNT_W-1:0] ERR_PERIOD = 21'sd524280;
  localparam logic signed [ERRX_W-1:0]  ERR_LIMIT  = 43'sd1048560;
  localparam logic signed [SUMQ_W-1:0]  ACC_LIMIT  = 36'sd1792000;
  localparam logic signed [DUTY_W-1:0]  DUTY_MID   = 12'sd1750;

  // divider step counts
  localparam logic [CNT_W-1:0] STEPS_NUM  = 6'd34;
  localparam logic [CNT_W-1:0] STEPS_GAIN = 6'd15;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_TARGET_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] CFG_TARGET_PHASE = 3'd1;
  localparam logic [IDX_W-1:0] CFG_PROP_DIVISOR = 3'd2;
  localparam logic [IDX_W-1:0] CFG_INTEG_GAIN   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_DERIV_GAIN   = 3'd4;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_NEG  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_POS  = 2'd2;

  // clamp a wide signed value to the accumulator limits
  function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [SUMQ_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > ACC_LIMIT) begin
      r = ACC_W'(ACC_LIMIT);
    end else if (v < -ACC_LIMIT) begin
      r = ACC_W'(-ACC_LIMIT);
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/incremental_pid_position_loop.sv
// The reset gains turn the integral term on by product and the derivative term off.
// One item is in work at a time; tready returns on the edge that loads the result,
// and a result still waiting in the output slot holds the final state until taken.
// The shared restoring divider forms one quotient bit per cycle:
// 34 steps per accumulator term and 15 more when a negative gain divides prop_divisor.
// Synchronous active-high reset restores the register defaults and clears the loop state.
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_position_loop (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input item
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [39:0]                 s_axis_tdata,   // measured_count, measured_phase
  // result item
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [39:0]                      m_axis_tdata,   // duty_compare, drive_direction,
                                                           // clamped_error, error_in_range, 0
  // configuration writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ippl_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [ippl_pkg::CFG_W-1:0]  cfg_data
);

  import ippl_pkg::*;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_ERR  = 4'd2;
  localparam logic [3:0] ST_NUM  = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_UPD  = 4'd5;
  localparam logic [3:0] ST_GAIN = 4'd6;
  localparam logic [3:0] ST_GDIV = 4'd7;
  localparam logic [3:0] ST_SUM  = 4'd8;

  // accumulator terms
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  // configuration registers
  logic signed [COUNT_W-1:0] target_count;
  logic signed [PHASE_W-1:0] target_phase;
  logic [PDIV_W-1:0]         prop_divisor;
  logic signed [GAIN_W-1:0]  integral_gain;
  logic signed [GAIN_W-1:0]  derivative_gain;

  // loop state
  logic signed [E_W-1:0]   last_error;
  logic signed [E_W-1:0]   error_before_last;
  logic signed [ACC_W-1:0] prop_accum;
  logic signed [ACC_W-1:0] integ_accum;
  logic signed [ACC_W-1:0] deriv_accum;
  logic                    was_in_range;

  // sequencer and work registers
  logic [3:0]                state;
  logic [1:0]                term;
  logic signed [COUNT_W-1:0] meas_count;
  logic signed [PHASE_W-1:0] meas_phase;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ERR_W-1:0]   err;
  logic                      in_range;
  logic [NUM_W-1:0]          dvd;
  logic [DVS_W-1:0]          rem;
  logic [DVS_W-1:0]          dvs;
  logic [CNT_W-1:0]          count;
  logic                      neg;

  // result register
  logic [DUTY_W-1:0]       out_duty;
  logic [DIR_W-1:0]        out_dir;
  logic signed [ERR_W-1:0] out_err;
  logic                    out_in_range;

  // combinational helpers
  logic signed [COUNT_W:0]  diff_count;
  logic signed [ERRX_W-1:0] err_wide;
  logic [PDIV_W-1:0]        prop_eff;
  logic signed [GAIN_W-1:0] gain;
  logic [GAIN_W-1:0]        gain_mag;
  logic signed [E_W-1:0]    e_cur;
  logic signed [NUM_W-1:0]  delta1;
  logic signed [NUM_W-1:0]  delta2;
  logic signed [NUM_W-1:0]  numer;
  logic [DVS_W:0]           rem_sh;
  logic                     q_bit;
  logic [DVS_W-1:0]         rem_next;
  logic [NUM_W-1:0]         dvd_next;
  logic [DVS_W-1:0]         gain_quot;
  logic signed [SUMQ_W-1:0] quot_s;
  logic signed [SUMQ_W-1:0] acc_sel;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [SUM3_W-1:0] sum3;
  logic signed [ACC_W-1:0]  sum_clamped;
  logic signed [DUTY_W-1:0] drive;
  logic                     in_fire;
  logic                     cfg_fire;
  logic                     out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_fire      = cfg_valid && cfg_ready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // position error before clamping
  always_comb begin
    diff_count = (COUNT_W+1)'(target_count) - (COUNT_W+1)'(meas_count);
    err_wide   = ERRX_W'(prod) + ERRX_W'(target_phase) - ERRX_W'(meas_phase);
  end

  // divisors and numerators
  always_comb begin
    prop_eff = (prop_divisor == '0) ? PDIV_W'(1) : prop_divisor;
    gain     = (term == TERM_I) ? integral_gain : derivative_gain;
    gain_mag = GAIN_W'(-gain);
    e_cur    = {err[ERR_W-1], err, 10'b0};
    delta1   = NUM_W'(e_cur) - NUM_W'(last_error);
    delta2   = delta1 - (NUM_W'(last_error) - NUM_W'(error_before_last));
    case (term)
      TERM_P:  numer = delta1;
      TERM_I:  numer = NUM_W'(e_cur);
      TERM_D:  numer = delta2;
      default: numer = delta1;
    endcase
  end

  // one restoring divider step
  always_comb begin
    rem_sh    = {rem, dvd[NUM_W-1]};
    q_bit     = (rem_sh >= {1'b0, dvs});
    rem_next  = q_bit ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
    dvd_next  = {dvd[NUM_W-2:0], q_bit};
    gain_quot = DVS_W'(dvd_next[PDIV_W-1:0]);
  end

  // accumulator update
  always_comb begin
    quot_s = neg ? -$signed({2'b00, dvd}) : $signed({2'b00, dvd});
    case (term)
      TERM_P:  acc_sel = SUMQ_W'(prop_accum);
      TERM_I:  acc_sel = SUMQ_W'(integ_accum);
      TERM_D:  acc_sel = SUMQ_W'(deriv_accum);
      default: acc_sel = SUMQ_W'(prop_accum);
    endcase
    acc_next = clamp_acc(acc_sel + quot_s);
  end

  // drive from the clamped sum
  always_comb begin
    sum3        = SUM3_W'(prop_accum) + SUM3_W'(integ_accum) + SUM3_W'(deriv_accum);
    sum_clamped = clamp_acc(SUMQ_W'(sum3));
    drive       = DUTY_W'(sum_clamped >>> 10);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      term            <= TERM_P;
      m_axis_tvalid   <= 1'b0;
      target_count    <= '0;
      target_phase    <= '0;
      prop_divisor    <= PDIV_W'(3000);
      integral_gain   <= GAIN_W'(10000);
      derivative_gain <= '0;
      last_error        <= '0;
      error_before_last <= '0;
      prop_accum        <= '0;
      integ_accum       <= '0;
      deriv_accum       <= '0;
      was_in_range      <= 1'b0;
    end else begin
      // drop the result once taken
      if (m_axis_tvalid && m_axis_tready && state != ST_SUM) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            meas_count <= s_axis_tdata[COUNT_W-1:0];
            meas_phase <= s_axis_tdata[COUNT_W+PHASE_W-1:COUNT_W];
            state      <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= PROD_W'(diff_count) * PROD_W'(ERR_PERIOD);
          state <= ST_ERR;
        end
        ST_ERR: begin
          // clamp, limits themselves count as out of range
          if (err_wide >= ERR_LIMIT) begin
            err      <= ERR_W'(ERR_LIMIT);
            in_range <= 1'b0;
          end else if (err_wide <= -ERR_LIMIT) begin
            err      <= ERR_W'(-ERR_LIMIT);
            in_range <= 1'b0;
          end else begin
            err      <= err_wide[ERR_W-1:0];
            in_range <= 1'b1;
          end
          term  <= TERM_P;
          dvs   <= DVS_W'(prop_eff);
          state <= ST_NUM;
        end
        ST_NUM: begin
          neg   <= numer[NUM_W-1];
          dvd   <= numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
          rem   <= '0;
          count <= STEPS_NUM;
          state <= ST_DIV;
        end
        ST_DIV: begin
          dvd   <= dvd_next;
          rem   <= rem_next;
          count <= count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          case (term)
            TERM_P: begin
              prop_accum <= acc_next;
              term       <= TERM_I;
              state      <= ST_GAIN;
            end
            TERM_I: begin
              // clear the integral on entry into range
              integ_accum <= (in_range && !was_in_range) ? '0 : acc_next;
              term        <= TERM_D;
              state       <= ST_GAIN;
            end
            default: begin
              deriv_accum <= acc_next;
              state       <= ST_SUM;
            end
          endcase
        end
        ST_GAIN: begin
          if (gain == '0) begin
            // skip a disabled term
            if (term == TERM_I) begin
              term <= TERM_D;
            end else begin
              state <= ST_SUM;
            end
          end else if (!gain[GAIN_W-1]) begin
            dvs   <= DVS_W'(prop_eff) * DVS_W'(gain[GAIN_W-2:0]);
            state <= ST_NUM;
          end else begin
            dvd   <= {prop_eff, (NUM_W-PDIV_W)'(0)};
            rem   <= '0;
            dvs   <= DVS_W'(gain_mag);
            count <= STEPS_GAIN;
            state <= ST_GDIV;
          end
        end
        ST_GDIV: begin
          dvd   <= dvd_next;
          rem   <= rem_next;
          count <= count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            dvs   <= (gain_quot == '0) ? DVS_W'(1) : gain_quot;
            state <= ST_NUM;
          end
        end
        ST_SUM: begin
          // load the result once the output slot is free
          if (out_free) begin
            out_duty          <= DUTY_W'(drive + DUTY_MID);
            out_dir           <= drive[DUTY_W-1] ? DIR_NEG :
                                 ((drive != '0) ? DIR_POS : DIR_STOP);
            out_err           <= err;
            out_in_range      <= in_range;
            m_axis_tvalid     <= 1'b1;
            error_before_last <= last_error;
            last_error        <= e_cur;
            was_in_range      <= in_range;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // register writes; a valid index also clears the loop state
      if (cfg_fire) begin
        case (cfg_index)
          CFG_TARGET_COUNT: target_count    <= cfg_data[COUNT_W-1:0];
          CFG_TARGET_PHASE: target_phase    <= cfg_data[PHASE_W-1:0];
          CFG_PROP_DIVISOR: prop_divisor    <= cfg_data[PDIV_W-1:0];
          CFG_INTEG_GAIN:   integral_gain   <= cfg_data[GAIN_W-1:0];
          CFG_DERIV_GAIN:   derivative_gain <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
        if (cfg_index == CFG_TARGET_COUNT || cfg_index == CFG_TARGET_PHASE ||
            cfg_index == CFG_PROP_DIVISOR || cfg_index == CFG_INTEG_GAIN ||
            cfg_index == CFG_DERIV_GAIN) begin
          last_error        <= '0;
          error_before_last <= '0;
          prop_accum        <= '0;
          integ_accum       <= '0;
          deriv_accum       <= '0;
          was_in_range      <= 1'b0;
        end
      end
    end
  end

  assign m_axis_tdata = {4'b0, out_in_range, out_err, out_dir, out_duty};

`ifndef SYNTHESIS
  // an accepted item starts the error product
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_MUL)
    else $error("accepted item did not start the sequencer");

  // divider remainder stays below the divisor
  a_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_GDIV) |-> (rem < dvs && dvs != '0))
    else $error("divider remainder out of range");

  // a result appears only from the final state
  a_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_SUM)
    else $error("result raised outside the final state");

  // the proportional and integral accumulators stay inside the clamp limits
  a_acc: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> (SUMQ_W'(integ_accum) <= ACC_LIMIT &&
                         SUMQ_W'(integ_accum) >= -ACC_LIMIT &&
                         SUMQ_W'(prop_accum) <= ACC_LIMIT &&
                         SUMQ_W'(prop_accum) >= -ACC_LIMIT))
    else $error("accumulator beyond limits");
`endif

endmodule

`default_nettype wire
